[design/cckb_pkg.sv]
// Shared types, widths and codes for the clipped color-keyed blitter.
// Used by cckb_front, cckb_engine and clipped_colorkey_blitter.
package cckb_pkg;

   // Field and datapath widths
   localparam int COORD_BITS     = 12;
   localparam int OFFSET_BITS    = 24;
   localparam int OUT_OFF_BITS   = 24;
   localparam int SRC_BITS       = 11;
   localparam int PITCH_BITS     = 13;
   localparam int KEY_BITS       = 9;
   localparam int PIX_BITS       = 8;
   localparam int KIND_BITS      = 2;
   localparam int CLIP_BITS      = COORD_BITS + 2;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 13;
   localparam int REQ_TDATA_BITS = 80;
   localparam int RSP_TDATA_BITS = 88;

   // Input function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   // Result kinds
   localparam logic [KIND_BITS-1:0] KIND_START = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_EMPTY = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_PIXEL = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_IDLE  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_DEST_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEST_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEST_PITCH  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SRC_PITCH   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_COLOR_KEY   = 3'd4;

   // Register reset values
   localparam logic [COORD_BITS-1:0] RST_DEST_WIDTH  = 12'd320;
   localparam logic [COORD_BITS-1:0] RST_DEST_HEIGHT = 12'd200;
   localparam logic [PITCH_BITS-1:0] RST_DEST_PITCH  = 13'd320;
   localparam logic [PITCH_BITS-1:0] RST_SRC_PITCH   = 13'd320;
   localparam logic [KEY_BITS-1:0]   RST_COLOR_KEY   = 9'h1FF;

   typedef struct packed {
      logic [COORD_BITS-1:0] dest_width;
      logic [COORD_BITS-1:0] dest_height;
      logic [PITCH_BITS-1:0] dest_pitch;
      logic [PITCH_BITS-1:0] src_pitch;
      logic [KEY_BITS-1:0]   color_key;
   } cfg_type;

   // Unpacked request transaction
   typedef struct packed {
      logic                  func;
      logic [COORD_BITS-1:0] dst_x;
      logic [COORD_BITS-1:0] dst_y;
      logic [SRC_BITS-1:0]   src_x;
      logic [SRC_BITS-1:0]   src_y;
      logic [SRC_BITS-1:0]   rect_width;
      logic [SRC_BITS-1:0]   rect_height;
      logic                  use_key;
      logic [PIX_BITS-1:0]   pixel;
   } req_item_type;

   // Item after clipping, held in the front register
   typedef struct packed {
      logic                func;
      logic                empty;
      logic                use_key;
      logic [PIX_BITS-1:0] pixel;
      logic [SRC_BITS-1:0] x;
      logic [SRC_BITS-1:0] y;
      logic [SRC_BITS:0]   sx;
      logic [SRC_BITS:0]   sy;
      logic [SRC_BITS-1:0] w;
      logic [SRC_BITS-1:0] h;
   } front_item_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]    kind;
      logic [OUT_OFF_BITS-1:0] dest_offset;
      logic [OUT_OFF_BITS-1:0] src_offset;
      logic                    write_enable;
      logic [PIX_BITS-1:0]     pixel_out;
      logic [COORD_BITS-1:0]   clip_width;
      logic [COORD_BITS-1:0]   clip_height;
      logic                    last;
   } rsp_item_type;

endpackage

[design/clipped_colorkey_blitter.sv]
// Clipped color-keyed 8bpp rectangle copy engine, top level.
// Use: a req_ transaction with tuser 0 starts a blit (position, source
// rectangle, keying flag); it is clipped against dest_width/dest_height
// and answered with kind 0 (clipped start offsets and size) or kind 1
// (empty, tlast set). Each req_ transaction with tuser 1 carries one
// source pixel and is answered with kind 2: destination and source byte
// offsets in row-major order and a write enable that drops for keyed
// pixels; tlast marks the final pixel. A pixel while idle yields kind 3.
// A start during a running blit drops that blit.
// Pipeline: a request is accepted into the front register (with clipping),
// then passes through the engine into the result register, which drives
// rsp_tvalid; a stall on rsp_tready can hold it in between. Throughput:
// one transaction per cycle while rsp_tready stays high, set by the
// combinational start multiply and the per-pixel offset add in the engine.
// Stall: while rsp_tready is low the result register holds and one more
// transaction is kept in the front register; req_tready then drops.
// Reset: clears both stages and the run; registers return to 320 x 200,
// pitches 320, color key disabled. csr_ writes are always accepted.
// Depends on cckb_pkg, cckb_front and cckb_engine.
module clipped_colorkey_blitter
   import cckb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // dst_x[11:0] dst_y[23:12] src_x[34:24] src_y[45:35] rect_width[56:46]
   // rect_height[67:57] use_key[68] pixel[76:69] zero[79:77]
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // func[0]
   input  logic                      req_tuser,
   // Result channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // dest_offset[23:0] src_offset[47:24] write_enable[48] pixel_out[56:49]
   // clip_width[68:57] clip_height[80:69] zero[87:81]
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // kind[1:0]
   output logic [KIND_BITS-1:0]      rsp_tuser,
   output logic                      rsp_tlast,
   // Configuration write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type        cfg_ff;
   req_item_type   req_item;
   front_item_type front_item;
   rsp_item_type   eng_rsp;
   rsp_item_type   rsp_ff;
   logic           front_valid_ff, front_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_accept, rsp_load, eng_active;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_width  <= RST_DEST_WIDTH;
         cfg_ff.dest_height <= RST_DEST_HEIGHT;
         cfg_ff.dest_pitch  <= RST_DEST_PITCH;
         cfg_ff.src_pitch   <= RST_SRC_PITCH;
         cfg_ff.color_key   <= RST_COLOR_KEY;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DEST_WIDTH:  cfg_ff.dest_width  <= csr_data[COORD_BITS-1:0];
            REG_DEST_HEIGHT: cfg_ff.dest_height <= csr_data[COORD_BITS-1:0];
            REG_DEST_PITCH:  cfg_ff.dest_pitch  <= csr_data;
            REG_SRC_PITCH:   cfg_ff.src_pitch   <= csr_data;
            REG_COLOR_KEY:   cfg_ff.color_key   <= csr_data[KEY_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Unpack the request transaction
   always_comb begin
      req_item.func        = req_tuser;
      req_item.dst_x       = req_tdata[11:0];
      req_item.dst_y       = req_tdata[23:12];
      req_item.src_x       = req_tdata[34:24];
      req_item.src_y       = req_tdata[45:35];
      req_item.rect_width  = req_tdata[56:46];
      req_item.rect_height = req_tdata[67:57];
      req_item.use_key     = req_tdata[68];
      req_item.pixel       = req_tdata[76:69];
   end

   // Pipeline handshake: advance front into result when result frees up
   assign rsp_load   = front_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !front_valid_ff || rsp_load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (req_accept) begin
         front_valid_in = 1'b1;
      end else if (rsp_load) begin
         front_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   cckb_front u_front (
      .clock   (clock),
      .load    (req_accept),
      .cfg     (cfg_ff),
      .req     (req_item),
      .item_ff (front_item)
   );

   cckb_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .item   (front_item),
      .step   (rsp_load),
      .rsp    (eng_rsp),
      .active (eng_active)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= eng_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {7'b0, rsp_ff.clip_height, rsp_ff.clip_width, rsp_ff.pixel_out,
                        rsp_ff.write_enable, rsp_ff.src_offset, rsp_ff.dest_offset};

   // An empty blit always closes the run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_EMPTY) |-> rsp_tlast)
      else $error("empty blit result without tlast");

   // A final pixel leaves the engine idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (eng_rsp.kind == KIND_PIXEL) && eng_rsp.last |=> !eng_active)
      else $error("engine still active after final pixel");

   // A started blit has a non-empty clipped size
   a_start_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_START) |->
         (rsp_ff.clip_width != '0) && (rsp_ff.clip_height != '0))
      else $error("started blit with empty clipped size");

   // A pixel while idle writes nothing and closes nothing
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_IDLE) |-> !rsp_ff.write_enable && !rsp_tlast)
      else $error("idle pixel result with write enable or tlast");

endmodule

[design/cckb_front.sv]
// Front stage: clips a start transaction against the destination and
// registers the item. Depends on cckb_pkg.
module cckb_front
   import cckb_pkg::*;
(
   input  logic           clock,
   input  logic           load,
   input  cfg_type        cfg,
   input  req_item_type   req,
   output front_item_type item_ff
);

   logic signed [CLIP_BITS-1:0] x0, y0, w0, h0;
   logic signed [CLIP_BITS-1:0] x1, y1, w1, h1, sx1, sy1;
   logic signed [CLIP_BITS-1:0] w2, h2, dw, dh;
   front_item_type              item_in;

   // Clip top/left by moving the source origin, then right/bottom
   always_comb begin
      x0  = CLIP_BITS'(signed'(req.dst_x));
      y0  = CLIP_BITS'(signed'(req.dst_y));
      w0  = signed'(CLIP_BITS'(req.rect_width));
      h0  = signed'(CLIP_BITS'(req.rect_height));
      sx1 = signed'(CLIP_BITS'(req.src_x));
      sy1 = signed'(CLIP_BITS'(req.src_y));
      dw  = signed'(CLIP_BITS'(cfg.dest_width));
      dh  = signed'(CLIP_BITS'(cfg.dest_height));
      x1  = x0;
      y1  = y0;
      w1  = w0;
      h1  = h0;
      if (y0 < 0) begin
         sy1 = sy1 - y0;
         h1  = h0 + y0;
         y1  = '0;
      end
      if (x0 < 0) begin
         sx1 = sx1 - x0;
         w1  = w0 + x0;
         x1  = '0;
      end
      w2 = w1;
      h2 = h1;
      if (x1 + w1 > dw) begin
         w2 = dw - x1;
      end
      if (y1 + h1 > dh) begin
         h2 = dh - y1;
      end

      item_in.func    = req.func;
      item_in.empty   = (w2 <= 0) || (h2 <= 0);
      item_in.use_key = req.use_key;
      item_in.pixel   = req.pixel;
      item_in.x       = SRC_BITS'(x1);
      item_in.y       = SRC_BITS'(y1);
      item_in.sx      = (SRC_BITS+1)'(sx1);
      item_in.sy      = (SRC_BITS+1)'(sy1);
      item_in.w       = SRC_BITS'(w2);
      item_in.h       = SRC_BITS'(h2);
   end

   // Hold the item until the engine takes it
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

[design/cckb_engine.sv]
// Blit engine: run state, start offsets and per-pixel offset stepping.
// Depends on cckb_pkg; driven by the front register of cckb_front.
module cckb_engine
   import cckb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  front_item_type item,
   input  logic           step,
   output rsp_item_type   rsp,
   output logic           active
);

   localparam int DPROD_BITS = SRC_BITS + PITCH_BITS;
   localparam int SPROD_BITS = SRC_BITS + 1 + PITCH_BITS;

   logic                   active_ff, active_in;
   logic                   keying_ff, keying_in;
   logic [OFFSET_BITS-1:0] dbase_ff, dbase_in;
   logic [OFFSET_BITS-1:0] sbase_ff, sbase_in;
   logic [SRC_BITS-1:0]    column_ff, column_in;
   logic [SRC_BITS-1:0]    row_ff, row_in;
   logic [SRC_BITS-1:0]    run_w_ff, run_w_in;
   logic [SRC_BITS-1:0]    run_h_ff, run_h_in;

   logic [DPROD_BITS-1:0]  dprod;
   logic [SPROD_BITS-1:0]  sprod;
   logic [OFFSET_BITS-1:0] d0, s0, dpix, spix;
   logic [SRC_BITS:0]      column_inc, row_inc;
   logic                   skip;

   // Start offsets: row times pitch plus column
   assign dprod = DPROD_BITS'(item.y) * DPROD_BITS'(cfg.dest_pitch);
   assign sprod = SPROD_BITS'(item.sy) * SPROD_BITS'(cfg.src_pitch);
   assign d0    = OFFSET_BITS'(dprod) + OFFSET_BITS'(item.x);
   assign s0    = OFFSET_BITS'(sprod) + OFFSET_BITS'(item.sx);

   // Pixel offsets and keying
   assign dpix       = dbase_ff + OFFSET_BITS'(column_ff);
   assign spix       = sbase_ff + OFFSET_BITS'(column_ff);
   assign column_inc = (SRC_BITS+1)'(column_ff) + 1'b1;
   assign row_inc    = (SRC_BITS+1)'(row_ff) + 1'b1;
   assign skip       = keying_ff && !cfg.color_key[KEY_BITS-1]
                       && (item.pixel == cfg.color_key[PIX_BITS-1:0]);

   always_comb begin
      rsp       = '0;
      active_in = active_ff;
      keying_in = keying_ff;
      dbase_in  = dbase_ff;
      sbase_in  = sbase_ff;
      column_in = column_ff;
      row_in    = row_ff;
      run_w_in  = run_w_ff;
      run_h_in  = run_h_ff;
      case (item.func)
         FUNC_START: begin
            if (item.empty) begin
               rsp.kind  = KIND_EMPTY;
               rsp.last  = 1'b1;
               active_in = 1'b0;
            end else begin
               rsp.kind        = KIND_START;
               rsp.dest_offset = OUT_OFF_BITS'(d0);
               rsp.src_offset  = OUT_OFF_BITS'(s0);
               rsp.clip_width  = COORD_BITS'(item.w);
               rsp.clip_height = COORD_BITS'(item.h);
               active_in       = 1'b1;
               keying_in       = item.use_key;
               dbase_in        = d0;
               sbase_in        = s0;
               column_in       = '0;
               row_in          = '0;
               run_w_in        = item.w;
               run_h_in        = item.h;
            end
         end
         default: begin
            if (!active_ff) begin
               rsp.kind = KIND_IDLE;
            end else begin
               rsp.kind         = KIND_PIXEL;
               rsp.dest_offset  = OUT_OFF_BITS'(dpix);
               rsp.src_offset   = OUT_OFF_BITS'(spix);
               rsp.write_enable = !skip;
               rsp.pixel_out    = item.pixel;
               column_in        = SRC_BITS'(column_inc);
               // Advance to the next row at the end of a row
               if (column_inc >= (SRC_BITS+1)'(run_w_ff)) begin
                  column_in = '0;
                  row_in    = SRC_BITS'(row_inc);
                  dbase_in  = dbase_ff + OFFSET_BITS'(cfg.dest_pitch);
                  sbase_in  = sbase_ff + OFFSET_BITS'(cfg.src_pitch);
                  if (row_inc >= (SRC_BITS+1)'(run_h_ff)) begin
                     active_in = 1'b0;
                     row_in    = '0;
                     rsp.last  = 1'b1;
                  end
               end
            end
         end
      endcase
   end

   // Run control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (step) begin
         active_ff <= active_in;
      end
   end

   // Run payload
   always_ff @(posedge clock) begin
      if (step) begin
         keying_ff <= keying_in;
         dbase_ff  <= dbase_in;
         sbase_ff  <= sbase_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         run_w_ff  <= run_w_in;
         run_h_ff  <= run_h_in;
      end
   end

   assign active = active_ff;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for clipped_colorkey_blitter: directed and random blits
// against a transaction-level predictor of clipping, offsets and keying.
// Depends on cckb_pkg and the blitter RTL.
module tb_top;
   import cckb_pkg::*;

   // Predicts blit results and holds them until the block returns them
   class blit_scoreboard;
      logic [COORD_BITS-1:0] dest_width, dest_height;
      logic [PITCH_BITS-1:0] dest_pitch, src_pitch;
      logic [KEY_BITS-1:0]   color_key;
      bit                    running, keyed;
      logic [OFFSET_BITS-1:0] dest_base, src_base;
      int                    col, rown, run_w, run_h;
      rsp_item_type          awaited_results[$];
      int                    failures, reported;
      int                    n_start, n_empty, n_pixel, n_skip, n_idle;

      function new();
         dest_width  = RST_DEST_WIDTH;
         dest_height = RST_DEST_HEIGHT;
         dest_pitch  = RST_DEST_PITCH;
         src_pitch   = RST_SRC_PITCH;
         color_key   = RST_COLOR_KEY;
         running = 0; keyed = 0;
         dest_base = '0; src_base = '0;
         col = 0; rown = 0; run_w = 0; run_h = 0;
         failures = 0; reported = 0;
         n_start = 0; n_empty = 0; n_pixel = 0; n_skip = 0; n_idle = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_DEST_WIDTH:  dest_width = data[COORD_BITS-1:0];
            REG_DEST_HEIGHT: dest_height = data[COORD_BITS-1:0];
            REG_DEST_PITCH:  dest_pitch = data[PITCH_BITS-1:0];
            REG_SRC_PITCH:   src_pitch = data[PITCH_BITS-1:0];
            REG_COLOR_KEY:   color_key = data[KEY_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Clip a start rectangle against all four destination edges
      function void clip_rect(input req_item_type it, output int x, y, sx, sy, w, h);
         x  = $signed(it.dst_x);
         y  = $signed(it.dst_y);
         sx = int'(it.src_x);
         sy = int'(it.src_y);
         w  = int'(it.rect_width);
         h  = int'(it.rect_height);
         if (y < 0) begin
            sy -= y; h += y; y = 0;
         end
         if (x < 0) begin
            sx -= x; w += x; x = 0;
         end
         if (x + w > int'(dest_width)) w = int'(dest_width) - x;
         if (y + h > int'(dest_height)) h = int'(dest_height) - y;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // Advance the blit state for one accepted request and queue its result
      function void accept_request(req_item_type it);
         rsp_item_type e;
         int x, y, sx, sy, w, h;
         bit skip;
         e = '0;
         if (it.func == FUNC_START) begin
            clip_rect(it, x, y, sx, sy, w, h);
            if (w <= 0 || h <= 0) begin
               running = 0;
               e.kind = KIND_EMPTY;
               e.last = 1'b1;
               n_empty++;
            end else begin
               dest_base = OFFSET_BITS'(longint'(y) * longint'(dest_pitch) + longint'(x));
               src_base = OFFSET_BITS'(longint'(sy) * longint'(src_pitch) + longint'(sx));
               running = 1;
               keyed = it.use_key;
               col = 0; rown = 0; run_w = w; run_h = h;
               e.kind = KIND_START;
               e.dest_offset = OUT_OFF_BITS'(dest_base);
               e.src_offset = OUT_OFF_BITS'(src_base);
               e.clip_width = COORD_BITS'(w);
               e.clip_height = COORD_BITS'(h);
               n_start++;
            end
         end else if (!running) begin
            e.kind = KIND_IDLE;
            n_idle++;
         end else begin
            // Keying drops the write only for a non-negative key that matches
            skip = keyed && !color_key[KEY_BITS-1] && (it.pixel == color_key[PIX_BITS-1:0]);
            e.kind = KIND_PIXEL;
            e.dest_offset = OUT_OFF_BITS'(dest_base + OFFSET_BITS'(col));
            e.src_offset = OUT_OFF_BITS'(src_base + OFFSET_BITS'(col));
            e.write_enable = !skip;
            e.pixel_out = it.pixel;
            n_pixel++;
            if (skip) n_skip++;
            col++;
            if (col >= run_w) begin
               col = 0;
               rown++;
               dest_base = dest_base + OFFSET_BITS'(dest_pitch);
               src_base = src_base + OFFSET_BITS'(src_pitch);
               if (rown >= run_h) begin
                  running = 0;
                  rown = 0;
                  e.last = 1'b1;
               end
            end
         end
         awaited_results.push_back(e);
      endfunction

      // Match a returned result against the oldest prediction
      function void compare_result(rsp_item_type got);
         rsp_item_type e;
         bit bad;
         if (awaited_results.size() == 0) begin
            if (reported < 10)
               $display("[%0t] unexpected result: kind %0d dest %h src %h", $realtime,
                        got.kind, got.dest_offset, got.src_offset);
            reported++;
            failures++;
            return;
         end
         e = awaited_results.pop_front();
         bad = 0;
         if (got.kind !== e.kind) bad = 1;
         if (got.dest_offset !== e.dest_offset) bad = 1;
         if (got.src_offset !== e.src_offset) bad = 1;
         if (got.write_enable !== e.write_enable) bad = 1;
         if (got.pixel_out !== e.pixel_out) bad = 1;
         if (got.clip_width !== e.clip_width) bad = 1;
         if (got.clip_height !== e.clip_height) bad = 1;
         if (got.last !== e.last) bad = 1;
         if (bad) begin
            if (reported < 10) begin
               $display("[%0t] mismatch exp: kind %0d dest %h src %h we %0d pix %h cw %0d ch %0d last %0d",
                        $realtime, e.kind, e.dest_offset, e.src_offset, e.write_enable,
                        e.pixel_out, e.clip_width, e.clip_height, e.last);
               $display("            got: kind %0d dest %h src %h we %0d pix %h cw %0d ch %0d last %0d",
                        got.kind, got.dest_offset, got.src_offset, got.write_enable,
                        got.pixel_out, got.clip_width, got.clip_height, got.last);
            end
            reported++;
            failures++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [KIND_BITS-1:0]      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   blit_scoreboard sb = new();
   bit             steady = 0;
   int             settings = 0;
   req_item_type   seen_req;
   rsp_item_type   seen_rsp;

   clipped_colorkey_blitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly back-to-back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_item_type rand_item();
      req_item_type it;
      it.func        = 1'($urandom);
      it.dst_x       = COORD_BITS'($urandom);
      it.dst_y       = COORD_BITS'($urandom);
      it.src_x       = SRC_BITS'($urandom);
      it.src_y       = SRC_BITS'($urandom);
      it.rect_width  = SRC_BITS'($urandom);
      it.rect_height = SRC_BITS'($urandom);
      it.use_key     = 1'($urandom);
      it.pixel       = PIX_BITS'($urandom);
      return it;
   endfunction

   function automatic req_item_type mk_start(int x, y, sx, sy, w, h, bit k);
      req_item_type it;
      it = rand_item();
      it.func        = FUNC_START;
      it.dst_x       = COORD_BITS'(x);
      it.dst_y       = COORD_BITS'(y);
      it.src_x       = SRC_BITS'(sx);
      it.src_y       = SRC_BITS'(sy);
      it.rect_width  = SRC_BITS'(w);
      it.rect_height = SRC_BITS'(h);
      it.use_key     = k;
      return it;
   endfunction

   function automatic req_item_type mk_pixel(int p);
      req_item_type it;
      it = rand_item();
      it.func  = FUNC_PIXEL;
      it.pixel = PIX_BITS'(p);
      return it;
   endfunction

   // Coordinate inside the range, near the far clip edge, or just off the top or left
   function automatic logic [COORD_BITS-1:0] pick_coord(int limit);
      case ($urandom_range(0, 3))
         0: return COORD_BITS'(-int'($urandom_range(1, 5)));
         1: return COORD_BITS'(limit - int'($urandom_range(0, 5)));
         default: return COORD_BITS'($urandom_range(0, (limit > 0) ? limit - 1 : 0));
      endcase
   endfunction

   // Offer one request transaction; valid stays high into the next one unless a gap is picked
   task automatic send_item(input req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tdata  <= {3'b000, it.pixel, it.use_key, it.rect_height, it.rect_width,
                     it.src_y, it.src_x, it.dst_y, it.dst_x};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold requests until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Quiesce the block, drop any running blit, then write all registers
   task automatic apply_config(input int w, h, dp, sp, key);
      logic [CSR_IDX_BITS-1:0]  idx [5];
      logic [CSR_DATA_BITS-1:0] val [5];
      idx = '{REG_DEST_WIDTH, REG_DEST_HEIGHT, REG_DEST_PITCH, REG_SRC_PITCH, REG_COLOR_KEY};
      val = '{CSR_DATA_BITS'(w), CSR_DATA_BITS'(h), CSR_DATA_BITS'(dp), CSR_DATA_BITS'(sp),
              CSR_DATA_BITS'(key)};
      drain();
      if (sb.running) begin
         send_item(mk_start(0, 0, 0, 0, 0, 0, 1'b0));
         drain();
      end
      csr_valid <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
      settings++;
   endtask

   // Mostly complete blits with random content, the rest noise and broken runs
   task automatic run_phase(input int n_items);
      req_item_type it;
      int sent, npix, x, y, sx, sy, w, h;
      sent = 0;
      while (sent < n_items) begin
         it = rand_item();
         it.func = FUNC_START;
         if ($urandom_range(0, 9) < 8) begin
            it.rect_width  = SRC_BITS'($urandom_range(1, 6));
            it.rect_height = SRC_BITS'($urandom_range(1, 5));
            it.dst_x = pick_coord(int'(sb.dest_width));
            it.dst_y = pick_coord(int'(sb.dest_height));
         end
         send_item(it);
         sent++;
         sb.clip_rect(it, x, y, sx, sy, w, h);
         npix = (w > 0 && h > 0) ? w * h : 0;
         if (npix > 40) npix = $urandom_range(1, 40);
         case ($urandom_range(0, 9))
            0: npix = $urandom_range(0, npix);
            1: npix += $urandom_range(1, 3);
            default: ;
         endcase
         repeat (npix) begin
            it = mk_pixel($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) it.pixel = sb.color_key[PIX_BITS-1:0];
            send_item(it);
            sent++;
         end
      end
   endtask

   // Sample both channels at the clock edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         seen_req.func        = req_tuser;
         seen_req.dst_x       = req_tdata[11:0];
         seen_req.dst_y       = req_tdata[23:12];
         seen_req.src_x       = req_tdata[34:24];
         seen_req.src_y       = req_tdata[45:35];
         seen_req.rect_width  = req_tdata[56:46];
         seen_req.rect_height = req_tdata[67:57];
         seen_req.use_key     = req_tdata[68];
         seen_req.pixel       = req_tdata[76:69];
         sb.accept_request(seen_req);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.kind         = rsp_tuser;
         seen_rsp.dest_offset  = rsp_tdata[23:0];
         seen_rsp.src_offset   = rsp_tdata[47:24];
         seen_rsp.write_enable = rsp_tdata[48];
         seen_rsp.pixel_out    = rsp_tdata[56:49];
         seen_rsp.clip_width   = rsp_tdata[68:57];
         seen_rsp.clip_height  = rsp_tdata[80:69];
         seen_rsp.last         = rsp_tlast;
         sb.compare_result(seen_rsp);
      end
   end

   // Receiver: stall at random
   initial begin
      int n;
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Run limit
   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_START;
      csr_valid  <= 1'b0;
      csr_index  <= REG_DEST_WIDTH;
      csr_data   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: idle pixel, right and bottom clip at 320 x 200, zero-width blit
      send_item(mk_pixel(255));
      send_item(mk_start(300, 190, 0, 0, 30, 20, 1'b0));
      send_item(mk_start(5, 5, 0, 0, 0, 4, 1'b1));

      apply_config(8, 6, 10, 12, 5);
      // Top and left clip, keyed pixels including the key value
      send_item(mk_start(-2, -1, 3, 4, 5, 3, 1'b1));
      send_item(mk_pixel(5));
      send_item(mk_pixel(0));
      send_item(mk_pixel(255));
      send_item(mk_pixel(5));
      send_item(mk_pixel(7));
      send_item(mk_pixel(5));
      send_item(mk_pixel(5));
      // Keying off: the key value is still written
      send_item(mk_start(6, 5, 0, 0, 4, 4, 1'b0));
      send_item(mk_pixel(5));
      // Nothing left after clipping
      send_item(mk_start(2047, 0, 0, 0, 1, 1, 1'b0));
      send_item(mk_start(-2048, -2048, 2047, 2047, 2047, 2047, 1'b1));
      send_item(mk_start(0, -3, 0, 0, 4, 3, 1'b0));
      // Largest source, then a start that aborts it
      send_item(mk_start(0, 0, 2047, 2047, 2047, 2047, 1'b1));
      send_item(mk_pixel(255));
      send_item(mk_pixel(5));
      send_item(mk_start(1, 1, 0, 0, 1, 1, 1'b1));
      send_item(mk_pixel(5));

      apply_config(2048, 2048, 4096, 4096, 255);
      run_phase(100);
      apply_config(0, 17, 0, 0, 0);
      run_phase(40);
      apply_config(16, 0, 1, 4095, -1);
      run_phase(40);
      apply_config($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 4096),
                   $urandom_range(0, 4096), $urandom_range(0, 255));
      run_phase(120);
      steady = 1;
      apply_config($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 4096),
                   $urandom_range(0, 4096), $urandom_range(0, 255));
      run_phase(110);
      steady = 0;
      apply_config($urandom_range(0, 2048), $urandom_range(0, 2048), $urandom_range(0, 4096),
                   $urandom_range(0, 4096), $urandom_range(0, 255));
      run_phase(80);
      apply_config(5, 3, 0, 7, 0);
      run_phase(60);

      // Let the pipeline empty and watch for stray results
      drain();
      repeat (10) @(posedge clock);
      $display("Covered %0d blits started, %0d empty, %0d pixels (%0d keyed out), %0d idle pixels",
               sb.n_start, sb.n_empty, sb.n_pixel, sb.n_skip, sb.n_idle);
      $display("over %0d register settings; %0d failures", settings, sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
